FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/cswr_pkg.sv
// ----------------------------------------------------------------------------
// cswr_pkg
// Beat types and codes of the clock-sweep replacement store.
// ----------------------------------------------------------------------------
`default_nettype none

package cswr_pkg;

   // request codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // register indexes
   localparam int         CSR_INDEX_WIDTH = 2;
   localparam int         CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_USAGE = 2'd1;

   localparam logic [4:0] CAPACITY_RESET  = 5'd16;
   localparam logic [2:0] MAX_USAGE_RESET = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] key;
   } cswr_req_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  slot;
      logic [2:0]  usage;
      logic        evicted;
      logic [31:0] victim_key;
      logic [4:0]  occupancy;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } cswr_rsp_type;

endpackage

`default_nettype wire

FILE: hdl/cswr_ram.sv
// ----------------------------------------------------------------------------
// cswr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cswr_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/clock_sweep_replacement.sv
// ----------------------------------------------------------------------------
// clock_sweep_replacement
// Fully associative key store with clock-sweep victim choice.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | beat
//  req     | in  | req_valid/stall    | request code and key
//  rsp     | out | rsp_valid/stall    | hit, slot, usage, victim, totals
//  csr     | in  | csr_valid/ready    | register index and write data
//
//  One request at a time; entries live in one RAM read and written by a
//  sequencer, with a read state and an evaluate state per entry visited.
//  Lookup or insert scans the F filled slots in order, stopping early on a
//  hit; the rsp beat is registered from S_FIN. An insert that evicts then
//  steps the hand, at most 7*F+1 steps. Tick decays the hand's entry.
//  Reset is synchronous; no clearing pass, entries beyond the fill count are
//  never read. A stalled rsp beat holds the sequencer in its last state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clock_sweep_replacement #(
   parameter int ENTRIES   = 16,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_stall,
   input  wire cswr_pkg::cswr_req_type                     req_data,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output cswr_pkg::cswr_rsp_type                          rsp_data,
   input  wire logic                                       csr_valid,
   output logic                                            csr_ready,
   input  wire logic [cswr_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire logic [cswr_pkg::CSR_DATA_WIDTH-1:0]        csr_data
);

   localparam int IW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CAPW = (CW > 5) ? CW : 5;
   localparam int EW   = KEY_WIDTH + 3;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SRD   = 7'b0000010,
      S_SCMP  = 7'b0000100,
      S_MISS  = 7'b0001000,
      S_HRD   = 7'b0010000,
      S_HEVAL = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          filled_ff, filled_in;
   logic [IW-1:0]          hand_ff, hand_in;
   logic [31:0]            hits_ff, hits_in;
   logic [31:0]            misses_ff, misses_in;
   logic [4:0]             cap_ff, cap_in;
   logic [2:0]             maxu_ff, maxu_in;
   logic                   res_hit_ff, res_hit_in;
   logic [IW-1:0]          res_slot_ff, res_slot_in;
   logic [2:0]             res_usage_ff, res_usage_in;
   logic                   res_evict_ff, res_evict_in;
   logic [31:0]            res_victim_ff, res_victim_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   cswr_pkg::cswr_rsp_type rsp_data_ff, rsp_data_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [IW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]          ram_wr_data, ram_rd_data;

   logic [KEY_WIDTH-1:0]   rd_key;
   logic [2:0]             rd_usage;
   logic [2:0]             usage_bump;
   logic [KEY_WIDTH+31:0]  key_wide;
   logic [KEY_WIDTH-1:0]   key_req;
   logic [KEY_WIDTH+31:0]  victim_wide;
   logic [IW+3:0]          slot_wide;
   logic [CW+4:0]          occ_wide;
   logic [CW-1:0]          idx_p1;
   logic [CW-1:0]          hand_p1;
   logic [IW-1:0]          hand_next;
   logic [CAPW-1:0]        cap_ext;
   logic [CAPW-1:0]        cap_eff;
   logic [CAPW-1:0]        filled_ext;

   cswr_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // entry layout: key above, usage count in the low three bits
   assign rd_key      = ram_rd_data[EW-1:3];
   assign rd_usage    = ram_rd_data[2:0];
   assign usage_bump  = (rd_usage < maxu_ff) ? rd_usage + 3'd1 : rd_usage;

   assign key_wide    = {{KEY_WIDTH{1'b0}}, req_data.key};
   assign key_req     = key_wide[KEY_WIDTH-1:0];
   assign victim_wide = {32'b0, rd_key};
   assign slot_wide   = {4'b0, res_slot_ff};
   assign occ_wide    = {5'b0, filled_ff};

   assign idx_p1      = CW'(idx_ff) + CW'(1);
   assign hand_p1     = CW'(hand_ff) + CW'(1);
   assign hand_next   = (hand_p1 == filled_ff) ? '0 : hand_p1[IW-1:0];

   // capacity 0 acts as 1, above the entry count as the entry count
   assign cap_ext     = CAPW'(cap_ff);
   assign filled_ext  = CAPW'(filled_ff);
   always_comb begin
      cap_eff = cap_ext;
      if (cap_ext == '0) begin
         cap_eff = CAPW'(1);
      end else if (cap_ext > CAPW'(ENTRIES)) begin
         cap_eff = CAPW'(ENTRIES);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      filled_in     = filled_ff;
      hand_in       = hand_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      cap_in        = cap_ff;
      maxu_in       = maxu_ff;
      res_hit_in    = res_hit_ff;
      res_slot_in   = res_slot_ff;
      res_usage_in  = res_usage_ff;
      res_evict_in  = res_evict_ff;
      res_victim_in = res_victim_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = {key_ff, 3'd1};

      if (csr_valid) begin
         unique case (csr_index)
            cswr_pkg::CSR_CAPACITY:  cap_in  = csr_data[4:0];
            cswr_pkg::CSR_MAX_USAGE: maxu_in = csr_data[2:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.req_type;
               key_in        = key_req;
               idx_in        = '0;
               res_hit_in    = 1'b0;
               res_slot_in   = '0;
               res_usage_in  = 3'd0;
               res_evict_in  = 1'b0;
               res_victim_in = 32'd0;
               unique case (req_data.req_type) inside
                  cswr_pkg::OP_LOOKUP, cswr_pkg::OP_INSERT: begin
                     state_in = (filled_ff == '0) ? S_MISS : S_SRD;
                  end
                  cswr_pkg::OP_TICK: begin
                     res_slot_in = hand_ff;
                     state_in    = (filled_ff == '0) ? S_FIN : S_HRD;
                  end
                  default: begin
                     res_slot_in = hand_ff;
                     state_in    = S_FIN;
                  end
               endcase
            end
         end
         S_SRD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff;
            state_in    = S_SCMP;
         end
         S_SCMP: begin
            if (rd_key == key_ff) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = idx_ff;
               ram_wr_data  = {key_ff, usage_bump};
               res_hit_in   = 1'b1;
               res_slot_in  = idx_ff;
               res_usage_in = usage_bump;
               if (op_ff == cswr_pkg::OP_LOOKUP && hits_ff != '1) begin
                  hits_in = hits_ff + 32'd1;
               end
               state_in = S_FIN;
            end else if (idx_p1 == filled_ff) begin
               state_in = S_MISS;
            end else begin
               idx_in   = idx_p1[IW-1:0];
               state_in = S_SRD;
            end
         end
         S_MISS: begin
            if (op_ff == cswr_pkg::OP_LOOKUP) begin
               if (misses_ff != '1) begin
                  misses_in = misses_ff + 32'd1;
               end
               state_in = S_FIN;
            end else if (filled_ext < cap_eff) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = filled_ff[IW-1:0];
               ram_wr_data  = {key_ff, 3'd1};
               res_slot_in  = filled_ff[IW-1:0];
               res_usage_in = 3'd1;
               filled_in    = filled_ff + CW'(1);
               state_in     = S_FIN;
            end else begin
               state_in = S_HRD;
            end
         end
         S_HRD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = hand_ff;
            state_in    = S_HEVAL;
         end
         S_HEVAL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hand_ff;
            hand_in     = hand_next;
            if (op_ff == cswr_pkg::OP_TICK) begin
               ram_wr_data  = {rd_key, (rd_usage == 3'd0) ? 3'd0 : rd_usage - 3'd1};
               res_slot_in  = hand_ff;
               res_usage_in = (rd_usage == 3'd0) ? 3'd0 : rd_usage - 3'd1;
               state_in     = S_FIN;
            end else if (rd_usage != 3'd0) begin
               // second chance: decay and move on
               ram_wr_data = {rd_key, rd_usage - 3'd1};
               state_in    = S_HRD;
            end else begin
               ram_wr_data   = {key_ff, 3'd1};
               res_slot_in   = hand_ff;
               res_usage_in  = 3'd1;
               res_evict_in  = 1'b1;
               res_victim_in = victim_wide[31:0];
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.hit        = res_hit_ff;
               rsp_data_in.slot       = slot_wide[3:0];
               rsp_data_in.usage      = res_usage_ff;
               rsp_data_in.evicted    = res_evict_ff;
               rsp_data_in.victim_key = res_victim_ff;
               rsp_data_in.occupancy  = occ_wide[4:0];
               rsp_data_in.hit_total  = hits_ff;
               rsp_data_in.miss_total = misses_ff;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         hand_ff      <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         cap_ff       <= cswr_pkg::CAPACITY_RESET;
         maxu_ff      <= cswr_pkg::MAX_USAGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         hand_ff      <= hand_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         cap_ff       <= cap_in;
         maxu_ff      <= maxu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      res_hit_ff    <= res_hit_in;
      res_slot_ff   <= res_slot_in;
      res_usage_ff  <= res_usage_in;
      res_evict_ff  <= res_evict_in;
      res_victim_ff <= res_victim_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // hand always points into the filled range once anything is stored
   `ASSERT_IMPLY(a_hand_range, clock, reset, filled_ff != '0, CW'(hand_ff) < filled_ff)
   `ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, filled_ff <= CW'(ENTRIES))
   `ASSERT_NEXT(a_fill_mono, clock, reset, 1'b1, filled_ff >= $past(filled_ff))
   // finishing with a free output register must present a beat
   `ASSERT_NEXT(a_fin_loads, clock, reset,
                state_ff == S_FIN && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff)
   `ASSERT_IMPLY(a_scan_range, clock, reset, state_ff == S_SCMP, idx_p1 <= filled_ff)

endmodule

`default_nettype wire

FILE: tb/clock_sweep_replacement_tb.sv
// ----------------------------------------------------------------------------
// clock_sweep_replacement_tb
// Drives lookups, inserts, ticks and unknown requests into the clock-sweep
// store under several capacity and usage ceiling settings. Each accepted
// request is run through a local model of the store, and every result beat
// is checked field by field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_sweep_replacement_tb;

   localparam int         ENTRIES    = 16;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   logic                                       clock;
   logic                                       reset     = 1'b1;
   logic                                       req_valid = 1'b0;
   logic                                       req_stall;
   cswr_pkg::cswr_req_type                     req_data  = '0;
   logic                                       rsp_valid;
   logic                                       rsp_stall = 1'b0;
   cswr_pkg::cswr_rsp_type                     rsp_data;
   logic                                       csr_valid = 1'b0;
   logic                                       csr_ready;
   logic [cswr_pkg::CSR_INDEX_WIDTH-1:0]       csr_index = '0;
   logic [cswr_pkg::CSR_DATA_WIDTH-1:0]        csr_data  = '0;

   clock_sweep_replacement DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // model of the store
   logic [31:0]  stored_key [ENTRIES] = '{default: '0};
   logic [2:0]   use_count  [ENTRIES] = '{default: '0};
   int           fill_count    = 0;
   int           hand          = 0;
   logic [31:0]  hits          = '0;
   logic [31:0]  misses        = '0;
   logic [4:0]   cap_reg       = cswr_pkg::CAPACITY_RESET;
   logic [2:0]   usage_ceiling = cswr_pkg::MAX_USAGE_RESET;

   cswr_pkg::cswr_rsp_type predicted_outcomes [$];
   int           error_count = 0;
   int           burst_left  = 5;
   logic [31:0]  key_pool [32];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("FAIL clock_sweep_replacement");
      $finish;
   end

   function automatic cswr_pkg::cswr_rsp_type store_access(input cswr_pkg::cswr_req_type r);
      cswr_pkg::cswr_rsp_type o;
      int           found;
      int           cur;
      int           limit;
      o     = '0;
      limit = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
      found = -1;
      if (r.req_type == cswr_pkg::OP_LOOKUP || r.req_type == cswr_pkg::OP_INSERT) begin
         for (int i = 0; i < fill_count; i++)
            if (found < 0 && stored_key[i] == r.key) found = i;
      end
      case (r.req_type)
         cswr_pkg::OP_LOOKUP: begin
            if (found >= 0) begin
               if (use_count[found] < usage_ceiling) use_count[found]++;
               if (hits != '1) hits++;
               o.hit   = 1'b1;
               o.slot  = found[3:0];
               o.usage = use_count[found];
            end else if (misses != '1) begin
               misses++;
            end
         end
         cswr_pkg::OP_INSERT: begin
            if (found >= 0) begin
               if (use_count[found] < usage_ceiling) use_count[found]++;
               o.hit  = 1'b1;
               o.slot = found[3:0];
            end else if (fill_count < limit) begin
               o.slot                 = fill_count[3:0];
               stored_key[fill_count] = r.key;
               use_count[fill_count]  = 3'd1;
               fill_count++;
            end else begin
               // sweep: decay nonzero counts until a zero is under the hand
               if (hand >= fill_count) hand = hand % fill_count;
               cur = -1;
               while (cur < 0) begin
                  if (use_count[hand] > 0) use_count[hand]--;
                  else cur = hand;
                  hand = (hand + 1) % fill_count;
               end
               o.slot          = cur[3:0];
               o.evicted       = 1'b1;
               o.victim_key    = stored_key[cur];
               stored_key[cur] = r.key;
               use_count[cur]  = 3'd1;
            end
            o.usage = use_count[o.slot];
         end
         cswr_pkg::OP_TICK: begin
            if (fill_count > 0 && hand >= fill_count) hand = hand % fill_count;
            o.slot = hand[3:0];
            if (fill_count > 0) begin
               if (use_count[hand] > 0) use_count[hand]--;
               o.usage = use_count[hand];
               hand    = (hand + 1) % fill_count;
            end
         end
         default: o.slot = hand[3:0];
      endcase
      o.occupancy  = fill_count[4:0];
      o.hit_total  = hits;
      o.miss_total = misses;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin : rsp_check
      cswr_pkg::cswr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outcomes.size() == 0) begin
            report_mismatch("result beat with no prediction pending");
         end else begin
            want = predicted_outcomes.pop_front();
            check_field("hit", 32'(rsp_data.hit), 32'(want.hit));
            check_field("slot", 32'(rsp_data.slot), 32'(want.slot));
            check_field("usage", 32'(rsp_data.usage), 32'(want.usage));
            check_field("evicted", 32'(rsp_data.evicted), 32'(want.evicted));
            check_field("victim_key", rsp_data.victim_key, want.victim_key);
            check_field("occupancy", 32'(rsp_data.occupancy), 32'(want.occupancy));
            check_field("hit_total", rsp_data.hit_total, want.hit_total);
            check_field("miss_total", rsp_data.miss_total, want.miss_total);
         end
      end
   end

   // receiver stall pattern, switching between styles now and then
   always @(posedge clock) begin : rsp_stall_gen
      int stall_mode;
      int stall_span;
      int stall_count;
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(50, 400);
      end
      stall_span--;
      stall_count++;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ((stall_count % 8) < 3);
         default: rsp_stall <= ((stall_count % 40) < 12);
      endcase
   end

   task automatic send_req(input logic [1:0] op, input logic [31:0] key);
      cswr_pkg::cswr_req_type item;
      cswr_pkg::cswr_rsp_type outcome;
      item.req_type = op;
      item.key      = key;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcome            = store_access(item);
      predicted_outcomes = {predicted_outcomes, outcome};
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 30);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (predicted_outcomes.size() != 0) @(posedge clock);
   endtask

   // both registers written back to back, valid held across the two beats
   task automatic configure(input logic [7:0] cap_data, input logic [7:0] ceil_data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= cswr_pkg::CSR_CAPACITY;
      csr_data  <= cap_data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cap_reg = cap_data[4:0];
      csr_index <= cswr_pkg::CSR_MAX_USAGE;
      csr_data  <= ceil_data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      usage_ceiling = ceil_data[2:0];
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_store();
      configure(8'd3, 8'd2);
      send_req(cswr_pkg::OP_LOOKUP, 32'h0);
      send_req(cswr_pkg::OP_TICK, 32'h0);
      send_req(OP_UNKNOWN, 32'hFFFF_FFFF);
   endtask

   task automatic test_fill_touch_evict();
      send_req(cswr_pkg::OP_INSERT, 32'h0000_0000);
      send_req(cswr_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_req(cswr_pkg::OP_INSERT, 32'h0000_0000);
      repeat (3) send_req(cswr_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
      send_req(cswr_pkg::OP_LOOKUP, 32'h0000_0000);
      send_req(cswr_pkg::OP_INSERT, 32'h5A5A_5A5A);
      send_req(cswr_pkg::OP_INSERT, 32'hA5A5_A5A5);
      send_req(cswr_pkg::OP_TICK, 32'h1234_5678);
      send_req(cswr_pkg::OP_TICK, 32'h0);
      send_req(cswr_pkg::OP_LOOKUP, 32'h1234_5678);
      send_req(OP_UNKNOWN, 32'h0);
   endtask

   // capacity written as zero acts as one, and the ceiling at zero stops raises
   task automatic test_capacity_shrink();
      configure(8'h00, 8'h00);
      send_req(cswr_pkg::OP_INSERT, 32'hCAFE_0001);
      send_req(cswr_pkg::OP_LOOKUP, 32'hCAFE_0001);
      send_req(cswr_pkg::OP_INSERT, 32'hCAFE_0001);
      send_req(cswr_pkg::OP_INSERT, 32'hCAFE_0002);
      send_req(cswr_pkg::OP_INSERT, 32'hCAFE_0003);
      send_req(cswr_pkg::OP_TICK, 32'h0);
      send_req(OP_UNKNOWN, 32'hFFFF_FFFF);
   endtask

   task automatic run_random_phase(input logic [7:0] cap_data, input logic [7:0] ceil_data,
                                   input int count, input int pool_size);
      int          pick;
      logic [1:0]  op;
      logic [31:0] key;
      configure(cap_data, ceil_data);
      foreach (key_pool[i]) key_pool[i] = $urandom();
      for (int n = 0; n < count; n++) begin
         // halfway through, the sender holds off until the store has answered everything
         if (n == count / 2) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 40)      op = cswr_pkg::OP_LOOKUP;
         else if (pick < 78) op = cswr_pkg::OP_INSERT;
         else if (pick < 95) op = cswr_pkg::OP_TICK;
         else                op = OP_UNKNOWN;
         if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
         else key = $urandom();
         send_req(op, key);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(8'd16, 8'd5, 250, 20);
      run_random_phase(8'h01, 8'h00, 150, 3);
      run_random_phase(8'hE0, 8'hF8, 150, 4);
      run_random_phase(8'hFF, 8'hFF, 300, 24);
      run_random_phase(8'd4, 8'd1, 200, 8);
      run_random_phase(8'd17, 8'd3, 250, 30);
      run_random_phase(8'd9, 8'h1E, 250, 14);
      run_random_phase(8'd16, 8'd7, 250, 18);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_fill_touch_evict();
      test_capacity_shrink();
      test_random_traffic();
      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0 && predicted_outcomes.size() == 0) begin
         $display("PASS clock_sweep_replacement");
      end else begin
         $display("FAIL clock_sweep_replacement");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: clock_sweep_replacement.f
+incdir+hdl
hdl/cswr_pkg.sv
hdl/cswr_ram.sv
hdl/clock_sweep_replacement.sv
tb/clock_sweep_replacement_tb.sv
